// ----- src/cpu_alu_shift_condition_codes_assert.svh -----
// ----------------------------------------------------------------------------
// cpu_alu_shift_condition_codes assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_SHIFT_CONDITION_CODES_ASSERT_SVH
`define CPU_ALU_SHIFT_CONDITION_CODES_ASSERT_SVH

// same-cycle implication
`define ASCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ascc assertion failed");

// next-cycle implication
`define ASCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ascc assertion failed");

`endif

// ----- src/ascc_pkg.sv -----
// ----------------------------------------------------------------------------
// ascc_pkg
// Operation codes, size codes and size helpers for the ALU/shifter block
// ----------------------------------------------------------------------------
`default_nettype none

package ascc_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = 6;
	localparam int unsigned BIT_W  = $clog2(DATA_W);

	typedef logic [DATA_W-1:0] data_t;

	// operation codes
	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_ADDX = 4'd1;
	localparam logic [3:0] OP_SUB  = 4'd2;
	localparam logic [3:0] OP_SUBX = 4'd3;
	localparam logic [3:0] OP_CMP  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_OR   = 4'd6;
	localparam logic [3:0] OP_EOR  = 4'd7;
	localparam logic [3:0] OP_ASL  = 4'd8;
	localparam logic [3:0] OP_ASR  = 4'd9;
	localparam logic [3:0] OP_LSL  = 4'd10;
	localparam logic [3:0] OP_LSR  = 4'd11;
	localparam logic [3:0] OP_ROL  = 4'd12;
	localparam logic [3:0] OP_ROR  = 4'd13;
	localparam logic [3:0] OP_ROXL = 4'd14;
	localparam logic [3:0] OP_ROXR = 4'd15;

	// size codes, anything else is long
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;
	localparam logic [1:0] SIZE_LONG = 2'd2;

	function automatic data_t size_mask(input logic [1:0] sz);
		data_t m;
		unique case (sz)
			SIZE_BYTE: m = data_t'(32'h0000_00ff);
			SIZE_WORD: m = data_t'(32'h0000_ffff);
			default:   m = data_t'(32'hffff_ffff);
		endcase
		return m;
	endfunction

	// one-hot sign bit position
	function automatic data_t size_top(input logic [1:0] sz);
		data_t m;
		unique case (sz)
			SIZE_BYTE: m = data_t'(32'h0000_0080);
			SIZE_WORD: m = data_t'(32'h0000_8000);
			default:   m = data_t'(32'h8000_0000);
		endcase
		return m;
	endfunction

	// index of the last bit processed
	function automatic logic [BIT_W-1:0] size_last(input logic [1:0] sz);
		logic [BIT_W-1:0] l;
		unique case (sz)
			SIZE_BYTE: l = BIT_W'(7);
			SIZE_WORD: l = BIT_W'(15);
			default:   l = BIT_W'(31);
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

// ----- src/cpu_alu_shift_condition_codes.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_shift_condition_codes
// Bit-serial ALU and single-step shifter with an X/N/Z/V/C flag register
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_stall) carries action, size_code, both operands
//   and shift_count; a transfer happens when in_valid is high and in_stall low
// - output channel (out_valid/out_stall) carries the sized result and the five
//   updated flags; one result per input transfer, in order
// - add/sub/cmp/logic run one bit per cycle, LSB first, over the operand size:
//   a load step, then one step per bit (8, 16 or 32 bits), then a flag step
// - shifts and rotates step one position per cycle through the result register:
//   a load step, then shift_count steps, then a flag step
// - the bit/step loop sets the item time; one item is worked on at a time,
//   and in_stall is high from the transfer until its flags are written
// - a finished result sits in the output register; the next item is taken
//   while it waits, but that item's flags are held back until the register
//   frees up
// - reset clears the stored X and Z flags to zero and empties the output register
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_alu_shift_condition_codes (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [3:0]                    action,
	input  wire logic [1:0]                    size_code,
	input  wire logic [ascc_pkg::DATA_W-1:0]   source_value,
	input  wire logic [ascc_pkg::DATA_W-1:0]   target_value,
	input  wire logic [ascc_pkg::CNT_W-1:0]    shift_count,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [ascc_pkg::DATA_W-1:0]        result_value,
	output logic                               extend_out,
	output logic                               negative_out,
	output logic                               zero_out,
	output logic                               overflow_out,
	output logic                               carry_out
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ALU    = 2'd1;
	localparam logic [1:0] ST_SHIFT  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]                      state_q;
	logic [3:0]                      op_q;
	logic [1:0]                      size_q;
	ascc_pkg::data_t                 a_q;
	ascc_pkg::data_t                 b_q;
	ascc_pkg::data_t                 r_q;
	logic                            cy_q;
	logic [ascc_pkg::BIT_W-1:0]      bit_cnt_q;
	logic [ascc_pkg::CNT_W-1:0]      sh_cnt_q;
	logic                            shifted_q;
	logic                            c_q;
	logic                            v_q;
	logic                            x_flag_q;
	logic                            z_flag_q;
	logic                            out_valid_q;

	logic                            in_xfer;
	logic                            out_free;
	logic                            is_sub;
	logic                            is_arith;
	logic                            abit;
	logic                            bbit;
	logic                            sum_bit;
	logic                            cout;
	logic                            res_bit;
	logic                            alu_last;
	ascc_pkg::data_t                 mask;
	ascc_pkg::data_t                 top;
	logic                            msb;
	logic                            lsb;
	logic                            shift_left;
	logic                            in_bit;
	logic                            fill;
	ascc_pkg::data_t                 nv;
	logic                            nv_msb;
	logic                            fin_x;
	logic                            fin_z;
	logic                            fin_n;
	logic                            xin;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// stored X enters addx/subx
	assign xin = x_flag_q && ((action == ascc_pkg::OP_ADDX) || (action == ascc_pkg::OP_SUBX));

	// one bit of the serial adder or logic unit
	always_comb begin
		is_sub   = (op_q == ascc_pkg::OP_SUB) || (op_q == ascc_pkg::OP_SUBX) ||
			(op_q == ascc_pkg::OP_CMP);
		is_arith = (op_q <= ascc_pkg::OP_CMP);
		abit     = a_q[0];
		bbit     = is_sub ? !b_q[0] : b_q[0];
		sum_bit  = abit ^ bbit ^ cy_q;
		cout     = (abit & bbit) | (abit & cy_q) | (bbit & cy_q);
		unique case (op_q)
			ascc_pkg::OP_AND: res_bit = a_q[0] & b_q[0];
			ascc_pkg::OP_OR:  res_bit = a_q[0] | b_q[0];
			ascc_pkg::OP_EOR: res_bit = a_q[0] ^ b_q[0];
			default:          res_bit = sum_bit;
		endcase
		alu_last = (bit_cnt_q == ascc_pkg::size_last(size_q));
	end

	// one step of the shifter
	always_comb begin
		mask       = ascc_pkg::size_mask(size_q);
		top        = ascc_pkg::size_top(size_q);
		msb        = |(r_q & top);
		lsb        = r_q[0];
		shift_left = (op_q == ascc_pkg::OP_ASL) || (op_q == ascc_pkg::OP_LSL) ||
			(op_q == ascc_pkg::OP_ROL) || (op_q == ascc_pkg::OP_ROXL);
		unique case (op_q)
			ascc_pkg::OP_ROL:  in_bit = msb;
			ascc_pkg::OP_ROXL: in_bit = c_q;
			default:           in_bit = 1'b0;
		endcase
		unique case (op_q)
			ascc_pkg::OP_ASR:  fill = msb;
			ascc_pkg::OP_ROR:  fill = lsb;
			ascc_pkg::OP_ROXR: fill = c_q;
			default:           fill = 1'b0;
		endcase
		if (shift_left) begin
			nv = ((r_q << 1) & mask) | ascc_pkg::DATA_W'(in_bit);
		end else begin
			nv = (r_q >> 1) | (fill ? top : '0);
		end
		nv_msb = |(nv & top);
	end

	// flags written at the end of an item
	always_comb begin
		fin_n = msb;
		unique case (op_q)
			ascc_pkg::OP_ADD, ascc_pkg::OP_ADDX, ascc_pkg::OP_SUB, ascc_pkg::OP_SUBX,
			ascc_pkg::OP_ROXL, ascc_pkg::OP_ROXR:
				fin_x = c_q;
			ascc_pkg::OP_ASL, ascc_pkg::OP_ASR, ascc_pkg::OP_LSL, ascc_pkg::OP_LSR:
				fin_x = shifted_q ? c_q : x_flag_q;
			default:
				fin_x = x_flag_q;
		endcase
		if ((op_q == ascc_pkg::OP_ADDX) || (op_q == ascc_pkg::OP_SUBX)) begin
			fin_z = (r_q != '0) ? 1'b0 : z_flag_q;
		end else begin
			fin_z = (r_q == '0);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (action >= ascc_pkg::OP_ASL) begin
							state_q <= (shift_count == '0) ? ST_FINISH : ST_SHIFT;
						end else begin
							state_q <= ST_ALU;
						end
					end
				end
				ST_ALU: begin
					if (alu_last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_SHIFT: begin
					if (sh_cnt_q == ascc_pkg::CNT_W'(1)) begin
						state_q <= ST_FINISH;
					end
				end
				default: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// operand, result and step registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q      <= action;
			size_q    <= size_code;
			a_q       <= target_value & ascc_pkg::size_mask(size_code);
			b_q       <= source_value & ascc_pkg::size_mask(size_code);
			bit_cnt_q <= '0;
			sh_cnt_q  <= shift_count;
			shifted_q <= (shift_count != '0);
			v_q       <= 1'b0;
			if ((action == ascc_pkg::OP_SUB) || (action == ascc_pkg::OP_SUBX) ||
				(action == ascc_pkg::OP_CMP)) begin
				cy_q <= !xin;
			end else begin
				cy_q <= xin;
			end
			if (action >= ascc_pkg::OP_ASL) begin
				r_q <= target_value & ascc_pkg::size_mask(size_code);
				c_q <= (action >= ascc_pkg::OP_ROXL) ? x_flag_q : 1'b0;
			end else begin
				r_q <= '0;
				c_q <= 1'b0;
			end
		end else if (state_q == ST_ALU) begin
			r_q[bit_cnt_q] <= res_bit;
			a_q            <= a_q >> 1;
			b_q            <= b_q >> 1;
			cy_q           <= cout;
			bit_cnt_q      <= bit_cnt_q + 1'b1;
			if (alu_last) begin
				v_q <= is_arith && (abit == bbit) && (sum_bit != abit);
				c_q <= is_arith && (is_sub ? !cout : cout);
			end
		end else if (state_q == ST_SHIFT) begin
			r_q      <= nv;
			c_q      <= shift_left ? msb : lsb;
			sh_cnt_q <= sh_cnt_q - 1'b1;
			if ((op_q == ascc_pkg::OP_ASL) && (msb != nv_msb)) begin
				v_q <= 1'b1;
			end
		end
	end

	// condition code register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_flag_q <= 1'b0;
			z_flag_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			x_flag_q <= fin_x;
			z_flag_q <= fin_z;
		end
	end

	// output register, loaded when the previous transfer has gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			result_value <= r_q;
			extend_out   <= fin_x;
			negative_out <= fin_n;
			zero_out     <= fin_z;
			overflow_out <= v_q;
			carry_out    <= c_q;
		end
	end

endmodule

`default_nettype wire

// ----- src/ascc_checker.sv -----
// ----------------------------------------------------------------------------
// ascc_checker
// Port-level checks for cpu_alu_shift_condition_codes, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_alu_shift_condition_codes_assert.svh"

module ascc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic [3:0]                  action,
	input wire logic [1:0]                  size_code,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [ascc_pkg::DATA_W-1:0] result_value,
	input wire logic                        negative_out,
	input wire logic                        zero_out,
	input wire logic                        overflow_out,
	input wire logic                        carry_out
);

	logic [3:0] pend_op_q;
	logic [1:0] pend_sz_q;
	logic [3:0] shown_op_q;
	logic [1:0] shown_sz_q;
	logic       prev_valid_q;
	logic       prev_stall_q;
	logic       fresh;
	logic [3:0] cur_op;
	logic [1:0] cur_sz;
	logic       cur_byte;
	logic       cur_logic;
	logic       cur_keepz;

	// track which transfer the shown result belongs to
	assign fresh     = out_valid && (!prev_valid_q || !prev_stall_q);
	assign cur_op    = fresh ? pend_op_q : shown_op_q;
	assign cur_sz    = fresh ? pend_sz_q : shown_sz_q;
	assign cur_byte  = (cur_sz == ascc_pkg::SIZE_BYTE);
	assign cur_logic = (cur_op == ascc_pkg::OP_AND) || (cur_op == ascc_pkg::OP_OR) ||
		(cur_op == ascc_pkg::OP_EOR);
	assign cur_keepz = (cur_op == ascc_pkg::OP_ADDX) || (cur_op == ascc_pkg::OP_SUBX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_stall_q <= 1'b0;
		end else begin
			prev_valid_q <= out_valid;
			prev_stall_q <= out_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pend_op_q <= action;
			pend_sz_q <= size_code;
		end
		if (fresh) begin
			shown_op_q <= pend_op_q;
			shown_sz_q <= pend_sz_q;
		end
	end

	// stalled result holds
	`ASCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(result_value) && $stable(carry_out))
	// busy right after taking an item
	`ASCC_ASSERT_NEXT(a_busy_after_xfer, in_valid && !in_stall, in_stall)
	// byte results are clipped
	`ASCC_ASSERT_IMPL(a_byte_clip, out_valid && cur_byte, result_value[31:8] == 24'd0)
	// logic operations clear V and C
	`ASCC_ASSERT_IMPL(a_logic_vc, out_valid && cur_logic, !overflow_out && !carry_out)
	// Z follows the result outside the extend forms, and Z and N are never both set
	`ASCC_ASSERT_IMPL(a_zero_flag, out_valid && !cur_keepz,
		zero_out == (result_value == '0) && (!zero_out || !negative_out))

endmodule

bind cpu_alu_shift_condition_codes ascc_checker u_ascc_checker (.*);

`default_nettype wire

// ----- tb/cpu_alu_shift_condition_codes_tb.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_shift_condition_codes_tb
// Self-checking bench for the ALU/shifter with X/N/Z/V/C flags. A directed
// set covers every operation, the operand extremes, zero and oversized shift
// counts and the extend forms. A random set then runs under idle bursts on
// both channels and one long output hold. Each accepted transfer is predicted
// against a private copy of the flags, and each result is checked field by
// field in order.
// ----------------------------------------------------------------------------

module cpu_alu_shift_condition_codes_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1330;
	localparam int CALM_ITEMS   = 150;
	localparam int PRESSURE_AT  = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1000000;

	// one predicted result with its flags
	typedef struct packed {
		ascc_pkg::data_t value;
		logic            x;
		logic            n;
		logic            z;
		logic            v;
		logic            c;
	} cc_result_t;

	// flag predictor and in-order result store
	class alu_flag_board;
		logic       x_flag;
		logic       n_flag;
		logic       z_flag;
		logic       v_flag;
		logic       c_flag;
		cc_result_t due_results[$];
		int         errors;

		function new();
			x_flag = 1'b0;
			n_flag = 1'b0;
			z_flag = 1'b0;
			v_flag = 1'b0;
			c_flag = 1'b0;
			errors = 0;
		endfunction

		// work out the result and flags of one accepted transfer
		function void note_transfer(logic [3:0] act, logic [1:0] sz, ascc_pkg::data_t src,
				ascc_pkg::data_t tgt, logic [5:0] cnt);
			ascc_pkg::data_t mask, top, s, t, r, val, nv;
			int unsigned     width;
			int              i;
			logic [32:0]     wide;
			logic            c, v, x, keepz, prev;
			cc_result_t      want;

			case (sz)
				ascc_pkg::SIZE_BYTE: begin
					mask = 32'h0000_00ff;
					width = 8;
				end
				ascc_pkg::SIZE_WORD: begin
					mask = 32'h0000_ffff;
					width = 16;
				end
				default: begin
					mask = 32'hffff_ffff;
					width = 32;
				end
			endcase
			top = mask ^ (mask >> 1);
			s = src & mask;
			t = tgt & mask;
			r = '0;
			c = 1'b0;
			v = 1'b0;
			x = x_flag;
			keepz = 1'b0;

			case (act)
				ascc_pkg::OP_ADD, ascc_pkg::OP_ADDX: begin
					wide = {1'b0, t} + {1'b0, s} + 33'(x_flag && act == ascc_pkg::OP_ADDX);
					r = wide[31:0] & mask;
					v = |(~(t ^ s) & (t ^ r) & top);
					c = wide[width];
					x = c;
					keepz = (act == ascc_pkg::OP_ADDX);
				end
				ascc_pkg::OP_SUB, ascc_pkg::OP_SUBX, ascc_pkg::OP_CMP: begin
					wide = {1'b0, t} - {1'b0, s} - 33'(x_flag && act == ascc_pkg::OP_SUBX);
					r = wide[31:0] & mask;
					v = |((t ^ s) & (t ^ r) & top);
					c = wide[width];
					if (act != ascc_pkg::OP_CMP) x = c;
					keepz = (act == ascc_pkg::OP_SUBX);
				end
				ascc_pkg::OP_AND: r = t & s;
				ascc_pkg::OP_OR:  r = t | s;
				ascc_pkg::OP_EOR: r = t ^ s;
				default: begin
					// shifts and rotates, one bit per count
					val = t;
					if (act == ascc_pkg::OP_ROXL || act == ascc_pkg::OP_ROXR) c = x_flag;
					for (i = 0; i < int'(cnt); i++) begin
						prev = c;
						case (act)
							ascc_pkg::OP_ASL: begin
								c = |(val & top);
								nv = (val << 1) & mask;
								if (|((val ^ nv) & top)) v = 1'b1;
								val = nv;
							end
							ascc_pkg::OP_ASR: begin
								c = val[0];
								val = (val >> 1) | (val & top);
							end
							ascc_pkg::OP_LSL: begin
								c = |(val & top);
								val = (val << 1) & mask;
							end
							ascc_pkg::OP_LSR: begin
								c = val[0];
								val = val >> 1;
							end
							ascc_pkg::OP_ROL: begin
								c = |(val & top);
								val = ((val << 1) & mask) | ascc_pkg::data_t'(c);
							end
							ascc_pkg::OP_ROR: begin
								c = val[0];
								val = (val >> 1) | (c ? top : '0);
							end
							ascc_pkg::OP_ROXL: begin
								c = |(val & top);
								val = ((val << 1) & mask) | ascc_pkg::data_t'(prev);
							end
							ascc_pkg::OP_ROXR: begin
								c = val[0];
								val = (val >> 1) | (prev ? top : '0);
							end
							default: ;
						endcase
					end
					r = val & mask;
					if (act <= ascc_pkg::OP_LSR) begin
						if (cnt != 0) x = c;
					end else if (act >= ascc_pkg::OP_ROXL) begin
						x = c;
					end
				end
			endcase

			// flag register update
			z_flag = keepz ? (r == 0 && z_flag) : (r == 0);
			n_flag = |(r & top);
			v_flag = v;
			c_flag = c;
			x_flag = x;

			want.value = r;
			want.x = x_flag;
			want.n = n_flag;
			want.z = z_flag;
			want.v = v_flag;
			want.c = c_flag;
			due_results.push_back(want);
		endfunction

		function void compare_bit(string name, logic want, logic got);
			if (want !== got) begin
				$error("%s: expected %b, got %b", name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(ascc_pkg::data_t value, logic x, logic n, logic z,
				logic v, logic c);
			cc_result_t want;
			if (due_results.size() == 0) begin
				$error("result transfer with nothing pending: result_value %h", value);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (want.value !== value) begin
				$error("result_value: expected %h, got %h", want.value, value);
				errors++;
			end
			compare_bit("extend_out", want.x, x);
			compare_bit("negative_out", want.n, n);
			compare_bit("zero_out", want.z, z);
			compare_bit("overflow_out", want.v, v);
			compare_bit("carry_out", want.c, c);
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [3:0]      action = ascc_pkg::OP_ADD;
	logic [1:0]      size_code = ascc_pkg::SIZE_BYTE;
	ascc_pkg::data_t source_value = '0;
	ascc_pkg::data_t target_value = '0;
	logic [5:0]      shift_count = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	ascc_pkg::data_t result_value;
	logic            extend_out;
	logic            negative_out;
	logic            zero_out;
	logic            overflow_out;
	logic            carry_out;

	alu_flag_board board = new();
	int            sent = 0;
	int            cycles = 0;
	logic          calm = 1'b0;
	logic          hold_request = 1'b0;
	logic          hold_done = 1'b0;
	int            hold_left = 0;

	cpu_alu_shift_condition_codes i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.size_code    (size_code),
		.source_value (source_value),
		.target_value (target_value),
		.shift_count  (shift_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.extend_out   (extend_out),
		.negative_out (negative_out),
		.zero_out     (zero_out),
		.overflow_out (overflow_out),
		.carry_out    (carry_out)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** cpu_alu_shift_condition_codes: FAILED **");
			$finish;
		end
	end

	// result side: check transfers, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(result_value, extend_out, negative_out, zero_out,
					overflow_out, carry_out);
			if (hold_request && !hold_done) begin
				// long hold so the block backs up into its input
				hold_done <= 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				hold_left = $urandom_range(1, 11) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one item, after an optional idle burst, and wait for its transfer
	task automatic offer_item(input logic [3:0] act, input logic [1:0] sz,
			input ascc_pkg::data_t src, input ascc_pkg::data_t tgt, input logic [5:0] cnt);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		size_code <= sz;
		source_value <= src;
		target_value <= tgt;
		shift_count <= cnt;
		do @(posedge clk); while (in_stall);
		board.note_transfer(act, sz, src, tgt, cnt);
		sent++;
	endtask

	// operand biased toward the sized extremes, with junk above the size now and then
	function automatic ascc_pkg::data_t pick_operand(logic [1:0] sz);
		ascc_pkg::data_t mask, top, base;
		mask = (sz == ascc_pkg::SIZE_BYTE) ? 32'h0000_00ff :
			(sz == ascc_pkg::SIZE_WORD) ? 32'h0000_ffff : '1;
		top = mask ^ (mask >> 1);
		case ($urandom_range(0, 9))
			0: base = '0;
			1: base = mask;
			2: base = top;
			3: base = top - 1;
			4: base = 1;
			default: base = $urandom;
		endcase
		if ($urandom_range(0, 1) == 0) base = (base & mask) | ($urandom & ~mask);
		return base;
	endfunction

	function automatic logic [5:0] pick_count(logic [1:0] sz);
		case ($urandom_range(0, 7))
			0: return 6'd0;
			1: return 6'd63;
			2: return 6'($urandom_range(1, (sz == ascc_pkg::SIZE_BYTE) ? 9 :
				(sz == ascc_pkg::SIZE_WORD) ? 17 : 33));
			default: return 6'($urandom_range(0, 63));
		endcase
	endfunction

	initial begin
		logic [1:0] sz;
		int         k;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: carries, extend chains, overflow, logic, shift corner cases
		offer_item(ascc_pkg::OP_ADD,  ascc_pkg::SIZE_BYTE, 32'h0000_0001, 32'h0000_00ff, 6'd0);
		offer_item(ascc_pkg::OP_ADDX, ascc_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0000, 6'd0);
		offer_item(ascc_pkg::OP_ADD,  ascc_pkg::SIZE_BYTE, 32'h0000_0080, 32'h0000_0080, 6'd0);
		offer_item(ascc_pkg::OP_SUBX, ascc_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0001, 6'd0);
		offer_item(ascc_pkg::OP_SUB,  ascc_pkg::SIZE_WORD, 32'h0000_0001, 32'h0000_0000, 6'd0);
		offer_item(ascc_pkg::OP_SUBX, ascc_pkg::SIZE_LONG, 32'h0000_0000, 32'h0000_0000, 6'd0);
		offer_item(ascc_pkg::OP_CMP,  ascc_pkg::SIZE_LONG, 32'h0000_0001, 32'h8000_0000, 6'd0);
		offer_item(ascc_pkg::OP_ADD,  ascc_pkg::SIZE_LONG, 32'h0000_0001, 32'h7fff_ffff, 6'd0);
		offer_item(ascc_pkg::OP_SUBX, ascc_pkg::SIZE_WORD, 32'h0000_0001, 32'h0000_8000, 6'd63);
		offer_item(ascc_pkg::OP_AND,  ascc_pkg::SIZE_BYTE, 32'hffff_ffff, 32'h0f0f_0f0f, 6'd63);
		offer_item(ascc_pkg::OP_OR,   ascc_pkg::SIZE_WORD, 32'hffff_0000, 32'h0000_0000, 6'd0);
		offer_item(ascc_pkg::OP_EOR,  ascc_pkg::SIZE_LONG, 32'hffff_ffff, 32'haaaa_aaaa, 6'd0);
		offer_item(ascc_pkg::OP_ASL,  ascc_pkg::SIZE_BYTE, 32'hffff_ffff, 32'h0000_0040, 6'd2);
		offer_item(ascc_pkg::OP_ASR,  ascc_pkg::SIZE_WORD, 32'h0000_0000, 32'h0000_8000, 6'd20);
		offer_item(ascc_pkg::OP_LSL,  ascc_pkg::SIZE_LONG, 32'h0000_0000, 32'hffff_ffff, 6'd63);
		offer_item(ascc_pkg::OP_LSR,  ascc_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0081, 6'd0);
		offer_item(ascc_pkg::OP_ROL,  ascc_pkg::SIZE_WORD, 32'h0000_0000, 32'h0000_8001, 6'd1);
		offer_item(ascc_pkg::OP_ROR,  ascc_pkg::SIZE_LONG, 32'h0000_0000, 32'h0000_0001, 6'd33);
		offer_item(ascc_pkg::OP_ROXL, ascc_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0080, 6'd0);
		offer_item(ascc_pkg::OP_ROXR, ascc_pkg::SIZE_LONG, 32'h0000_0000, 32'h0000_0001, 6'd1);
		offer_item(ascc_pkg::OP_ROXL, ascc_pkg::SIZE_BYTE, 32'h0000_0000, 32'h0000_0080, 6'd9);
		offer_item(ascc_pkg::OP_ASL,  ascc_pkg::SIZE_LONG, 32'h0000_0000, 32'h8000_0000, 6'd63);
		offer_item(ascc_pkg::OP_ROR,  ascc_pkg::SIZE_BYTE, 32'h0000_0000, 32'hffff_ff01, 6'd63);
		// size code three runs as long
		offer_item(ascc_pkg::OP_ADD,  2'd3, 32'h0000_0001, 32'hffff_ffff, 6'd0);
		offer_item(ascc_pkg::OP_ASL,  2'd3, 32'h0000_0000, 32'h8000_0001, 6'd0);

		// random part
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == PRESSURE_AT) hold_request <= 1'b1;
			if (k == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
			sz = 2'($urandom_range(0, 2));
			offer_item(4'($urandom_range(0, 15)), sz, pick_operand(sz), pick_operand(sz),
				pick_count(sz));
		end
		in_valid <= 1'b0;

		// drain, then allow for the longest item time
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		if (board.errors == 0 && board.due_results.size() == 0) begin
			$display("** cpu_alu_shift_condition_codes: PASSED **");
		end else begin
			$display("** cpu_alu_shift_condition_codes: FAILED **");
		end
		$finish;
	end

endmodule
